// File: src/idb_pkg.sv
// Shared types and constants for the indexed deque buffer.
package idb_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;
  localparam int REQ_W     = 3;

  typedef enum logic [REQ_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_FULL = 2'd2
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CAP_RD,
    S_CAP_TAKE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic cap_rd;
    logic cap_take;
    logic init_up;
    logic init_dn;
    logic sh_rd;
    logic sh_wr;
    logic put;
    logic finish;
  } idb_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ok;
    logic sh_more;
  } idb_sts_t;

endpackage

// File: src/idb_ctrl.sv
// Sequencer for the indexed deque buffer: steps each transaction through the datapath.
module idb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  idb_pkg::idb_sts_t sts,
  output idb_pkg::idb_cmd_t cmd,
  output logic              busy
);
  import idb_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.ok) begin
          state_next = S_FIN;
        end else begin
          unique case (sts.op) inside
            OP_PUSH_FRONT: begin
              cmd.init_up = 1'b1;
              state_next  = S_SHIFT_RD;
            end
            OP_PUSH_BACK: state_next = S_PUT;
            OP_POP_FRONT, OP_POP_BACK, OP_READ, OP_REMOVE_AT: state_next = S_CAP_RD;
            default: state_next = S_FIN;
          endcase
        end
      end
      S_CAP_RD: begin
        cmd.cap_rd = 1'b1;
        state_next = S_CAP_TAKE;
      end
      S_CAP_TAKE: begin
        cmd.cap_take = 1'b1;
        if (sts.op inside {OP_POP_FRONT, OP_REMOVE_AT}) begin
          cmd.init_dn = 1'b1;
          state_next  = S_SHIFT_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHIFT_RD: begin
        if (sts.sh_more) begin
          cmd.sh_rd  = 1'b1;
          state_next = S_SHIFT_WR;
        end else if (sts.op == OP_PUSH_FRONT) begin
          state_next = S_PUT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHIFT_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = S_SHIFT_RD;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: src/idb_dpath.sv
// Datapath for the indexed deque buffer: element memory, count, shift pointer and result registers.
module idb_dpath #(
  parameter int CAPACITY     = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  idb_pkg::idb_cmd_t                cmd,
  input  logic [idb_pkg::REQ_W-1:0]        req_type,
  input  logic [idb_pkg::DATA_W-1:0]       data_in,
  input  logic [idb_pkg::POS_W-1:0]        position,
  output idb_pkg::idb_sts_t                sts,
  output logic                             done,
  output logic [idb_pkg::DATA_W-1:0]       data_out,
  output idb_pkg::st_t                     status,
  output logic [idb_pkg::CNT_OUT_W-1:0]    count_out
);
  import idb_pkg::*;

  localparam int EW = (ELEMENT_BITS < DATA_W) ? ELEMENT_BITS : DATA_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [EW-1:0]     mem [CAPACITY];
  logic [EW-1:0]     rdata;
  op_t               req_q;
  logic [EW-1:0]     din_q;
  logic [POS_W-1:0]  pos_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     rem;
  logic              dir_up;
  logic [DATA_W-1:0] dout_q;

  logic              ok;
  logic [CW-1:0]     cap_addr;
  logic [CW-1:0]     count_new;
  logic [AW-1:0]     src_addr;
  logic [AW-1:0]     dst_addr;
  logic [AW-1:0]     put_addr;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  st_t               status_new;

  always_comb begin
    unique case (req_q)
      OP_PUSH_FRONT, OP_PUSH_BACK: ok = (count != CW'(CAPACITY));
      OP_POP_FRONT, OP_POP_BACK:   ok = (count != '0);
      OP_READ, OP_REMOVE_AT:       ok = (PW'(pos_q) < PW'(count));
      OP_CLEAR:                    ok = 1'b1;
      default:                     ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (req_q)
      OP_POP_FRONT: cap_addr = '0;
      OP_POP_BACK:  cap_addr = count - CW'(1);
      default:      cap_addr = CW'(pos_q);
    endcase
  end

  always_comb begin
    count_new = count;
    if (ok) begin
      unique case (req_q)
        OP_PUSH_FRONT, OP_PUSH_BACK:           count_new = count + CW'(1);
        OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: count_new = count - CW'(1);
        OP_CLEAR:                              count_new = '0;
        default:                               count_new = count;
      endcase
    end
  end

  always_comb begin
    if (ok) begin
      status_new = ST_OK;
    end else if (req_q == OP_PUSH_FRONT || req_q == OP_PUSH_BACK) begin
      status_new = ST_FULL;
    end else begin
      status_new = ST_ERR;
    end
  end

  assign src_addr = dir_up ? AW'(idx) : AW'(idx + CW'(1));
  assign dst_addr = dir_up ? AW'(idx + CW'(1)) : AW'(idx);
  assign put_addr = (req_q == OP_PUSH_FRONT) ? '0 : AW'(count);
  assign rd_addr  = cmd.cap_rd ? AW'(cap_addr) : src_addr;
  assign wr_addr  = cmd.put ? put_addr : dst_addr;
  assign wr_data  = cmd.put ? din_q : rdata;

  always_ff @(posedge clk) begin
    if (cmd.cap_rd || cmd.sh_rd) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.put || cmd.sh_wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= op_t'(req_type);
      din_q  <= data_in[EW-1:0];
      pos_q  <= position;
      dout_q <= '0;
    end
    if (cmd.cap_take) begin
      dout_q <= DATA_W'(rdata);
    end
    if (cmd.init_up) begin
      idx    <= count - CW'(1);
      rem    <= count;
      dir_up <= 1'b1;
    end else if (cmd.init_dn) begin
      idx    <= cap_addr;
      rem    <= count - CW'(1) - cap_addr;
      dir_up <= 1'b0;
    end else if (cmd.sh_wr) begin
      idx <= dir_up ? idx - CW'(1) : idx + CW'(1);
      rem <= rem - CW'(1);
    end
    if (cmd.finish) begin
      data_out  <= dout_q;
      status    <= status_new;
      count_out <= CNT_OUT_W'(count_new);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        count <= count_new;
      end
    end
  end

  assign sts.op      = req_q;
  assign sts.ok      = ok;
  assign sts.sh_more = (rem != '0);

endmodule

// File: src/indexed_deque_buffer.sv
// Top level of the indexed deque buffer: sequencer plus datapath.
//
//   channel   handshake               fields
//   request   start in, busy out      req_type, data_in, position
//   result    done out (one cycle)    data_out, status, count_out
//
// A transaction is taken at an edge with start high and busy low; done then rises
// for exactly one cycle. Clear and rejected requests finish without a memory access,
// push back writes the element once, read and pop back read it once, pop front and
// remove at also move each element behind the removed one down a place, and push
// front first moves every held element up a place. Each moved element costs a read
// and a write on the element memory. A new transaction may start in the done cycle.
// Reset clears the count; memory contents are not cleared.
module indexed_deque_buffer #(
  parameter int CAPACITY     = 16,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [idb_pkg::REQ_W-1:0]     req_type,
  input  logic [idb_pkg::DATA_W-1:0]    data_in,
  input  logic [idb_pkg::POS_W-1:0]     position,
  output logic                          done,
  output logic [idb_pkg::DATA_W-1:0]    data_out,
  output logic [1:0]                    status,
  output logic [idb_pkg::CNT_OUT_W-1:0] count_out
);
  import idb_pkg::*;

  idb_cmd_t cmd;
  idb_sts_t sts;
  st_t      status_q;

  idb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  idb_dpath #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (req_type),
    .data_in   (data_in),
    .position  (position),
    .sts       (sts),
    .done      (done),
    .data_out  (data_out),
    .status    (status_q),
    .count_out (count_out)
  );

  assign status = status_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a transaction is in flight");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
      start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      done && status != ST_OK |-> data_out == '0)
    else $error("failed transaction returned data");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
      cmd.put |-> !cmd.sh_wr && !cmd.cap_rd)
    else $error("memory port conflict");
`endif

endmodule

// File: tb/indexed_deque_buffer_tb.sv
// Self-checking testbench for indexed_deque_buffer: directed table, then biased random traffic.
module indexed_deque_buffer_tb;
  import idb_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int NUM_ROWS       = 30;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int QUIET_TAIL     = 200;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [REQ_W-1:0] REQ_UNDEFINED = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0]    data;
    st_t                  status;
    logic [CNT_OUT_W-1:0] count;
  } deque_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              typed;
    deque_result_t     want;
  } script_row_t;

  typedef enum logic [1:0] {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIXED
  } traffic_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     req_type = '0;
  logic [DATA_W-1:0]    data_in = '0;
  logic [POS_W-1:0]     position = '0;
  logic                 done;
  logic [DATA_W-1:0]    data_out;
  logic [1:0]           status;
  logic [CNT_OUT_W-1:0] count_out;

  // sideband travelling with each request: a typed expectation from the table
  logic                 row_is_typed = 1'b0;
  deque_result_t        row_expect = '0;

  logic [DATA_W-1:0]    held [CAPACITY];
  int                   held_count = 0;
  deque_result_t        awaited_results [$];
  int                   fault_count = 0;
  int                   cycles = 0;
  script_row_t          script [NUM_ROWS];

  indexed_deque_buffer #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (32)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .data_in   (data_in),
    .position  (position),
    .done      (done),
    .data_out  (data_out),
    .status    (status),
    .count_out (count_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic deque_result_t deque_apply(logic [REQ_W-1:0] req, logic [DATA_W-1:0] din,
                                                logic [POS_W-1:0] pos);
    deque_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (req)
      OP_PUSH_FRONT: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held_count; i > 0; i--) held[i] = held[i-1];
          held[0] = din;
          held_count++;
        end
      end
      OP_POP_FRONT: begin
        if (held_count == 0) begin
          r.status = ST_ERR;
        end else begin
          r.data = held[0];
          for (int i = 0; i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      OP_PUSH_BACK: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held[held_count] = din;
          held_count++;
        end
      end
      OP_POP_BACK: begin
        if (held_count == 0) begin
          r.status = ST_ERR;
        end else begin
          held_count--;
          r.data = held[held_count];
        end
      end
      OP_READ: begin
        if (int'(pos) >= held_count) r.status = ST_ERR;
        else r.data = held[pos];
      end
      OP_REMOVE_AT: begin
        if (int'(pos) >= held_count) begin
          r.status = ST_ERR;
        end else begin
          r.data = held[pos];
          for (int i = int'(pos); i + 1 < held_count; i++) held[i] = held[i+1];
          held_count--;
        end
      end
      OP_CLEAR: held_count = 0;
      default: r.status = ST_ERR;
    endcase
    r.count = held_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(traffic_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      TRAFFIC_FILL: begin
        if (roll < 40) return OP_PUSH_FRONT;
        if (roll < 80) return OP_PUSH_BACK;
        if (roll < 90) return OP_READ;
        if (roll < 95) return OP_REMOVE_AT;
        if (roll < 97) return OP_POP_FRONT;
        if (roll < 99) return OP_POP_BACK;
        return REQ_UNDEFINED;
      end
      TRAFFIC_DRAIN: begin
        if (roll < 25) return OP_POP_FRONT;
        if (roll < 50) return OP_POP_BACK;
        if (roll < 75) return OP_REMOVE_AT;
        if (roll < 90) return OP_READ;
        if (roll < 98) return OP_PUSH_BACK;
        if (roll < 99) return OP_CLEAR;
        return REQ_UNDEFINED;
      end
      default: begin
        if (roll < 15) return OP_PUSH_FRONT;
        if (roll < 30) return OP_PUSH_BACK;
        if (roll < 42) return OP_POP_FRONT;
        if (roll < 54) return OP_POP_BACK;
        if (roll < 74) return OP_READ;
        if (roll < 89) return OP_REMOVE_AT;
        if (roll < 90) return OP_CLEAR;
        if (roll < 91) return REQ_UNDEFINED;
        return OP_PUSH_FRONT;
      end
    endcase
  endfunction

  // holds the request until the block takes it; returns at the accepting edge
  task automatic issue(logic [REQ_W-1:0] req, logic [DATA_W-1:0] din, logic [POS_W-1:0] pos,
                       logic typed, deque_result_t want);
    start        <= 1'b1;
    req_type     <= req;
    data_in      <= din;
    position     <= pos;
    row_is_typed <= typed;
    row_expect   <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_all_returned();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (!rst) begin
      if (done) begin
        got = '{data_out, st_t'(status), count_out};
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected result: data %h status %0d count %0d",
                     got.data, got.status, got.count);
        end else begin
          want = awaited_results.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.count !== want.count) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d (data/status/count)",
                       want.data, want.status, want.count,
                       got.data, got.status, got.count);
          end
        end
      end
      if (start && !busy) begin
        want = deque_apply(req_type, data_in, position);
        if (row_is_typed) want = row_expect;
        awaited_results.push_back(want);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("indexed_deque_buffer_tb: FAIL");
    $finish;
  end

  initial begin
    traffic_t      mix;
    int            burst_left;
    bit            gappy;
    logic [POS_W-1:0] pos;

    script = '{
      '{OP_POP_FRONT,  32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_ERR, 5'd0}},
      '{OP_POP_BACK,   32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_ERR, 5'd0}},
      '{OP_READ,       32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_ERR, 5'd0}},
      '{OP_REMOVE_AT,  32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_ERR, 5'd0}},
      '{REQ_UNDEFINED, 32'hFFFF_FFFF, 4'd15, 1'b1, '{32'h0, ST_ERR, 5'd0}},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, ST_OK,  5'd1}},
      '{OP_PUSH_FRONT, 32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_OK,  5'd2}},
      '{OP_READ,       32'h0000_0000, 4'd1,  1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd2}},
      '{OP_READ,       32'h0000_0000, 4'd2,  1'b1, '{32'h0, ST_ERR, 5'd2}},
      '{OP_PUSH_FRONT, 32'h8000_0000, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'h0000_0001, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'h5A5A_5A5A, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'h1234_5678, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'h8765_4321, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'h0F0F_0F0F, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'hF0F0_F0F0, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'h3333_3333, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'hCCCC_CCCC, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'h7FFF_FFFF, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'hFFFF_FFFE, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'h0000_FFFF, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_BACK,  32'hFFFF_0000, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_PUSH_FRONT, 32'hDEAD_BEEF, 4'd0,  1'b1, '{32'h0, ST_FULL, 5'd16}},
      '{OP_PUSH_BACK,  32'hDEAD_BEEF, 4'd0,  1'b1, '{32'h0, ST_FULL, 5'd16}},
      '{OP_READ,       32'h0000_0000, 4'd15, 1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_REMOVE_AT,  32'h0000_0000, 4'd0,  1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_READ,       32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_ERR, 5'd15}},
      '{OP_REMOVE_AT,  32'h0000_0000, 4'd14, 1'b0, '{32'h0, ST_OK,  5'd0}},
      '{OP_CLEAR,      32'hFFFF_FFFF, 4'd15, 1'b1, '{32'h0, ST_OK,  5'd0}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      issue(script[r].req, script[r].data, script[r].pos, script[r].typed, script[r].want);
      if (r % 3 == 1) idle_for($urandom_range(1, 4));
    end

    // let the pipeline empty completely before random traffic
    wait_all_returned();

    burst_left = 0;
    mix        = TRAFFIC_MIXED;
    gappy      = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 40);
        mix        = traffic_t'($urandom_range(0, 2));
        gappy      = 1'($urandom_range(0, 1));
      end
      burst_left--;
      pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
      issue(pick_request(mix), $urandom, pos, 1'b0, '0);
      if (n < RANDOM_ITEMS - QUIET_TAIL) begin
        if ($urandom_range(0, 149) == 0) wait_all_returned();
        else if (gappy && $urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
      end
    end

    wait_all_returned();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0)
      $display("indexed_deque_buffer_tb: PASS");
    else
      $display("indexed_deque_buffer_tb: FAIL");
    $finish;
  end

endmodule

// File: files.f
src/idb_pkg.sv
src/idb_ctrl.sv
src/idb_dpath.sv
src/indexed_deque_buffer.sv
tb/indexed_deque_buffer_tb.sv
